// ===== hdl/spq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the stable sorted priority queue.
// Depends on nothing; used by spq_cell and stable_priority_queue_top.
package spq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VALUE_W       = 32;
    localparam int PRIO_W        = 16;
    localparam int STATUS_W      = 2;
    localparam int OCC_W         = 5;

    typedef enum logic {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Contents of one queue cell.
    typedef struct packed {
        logic                      valid;
        logic signed [VALUE_W-1:0] value;
        logic        [PRIO_W-1:0]  prio;
    } cell_data_t;

    // Operation broadcast to every cell in the chain.
    typedef struct packed {
        logic                      en;
        cmd_t                      cmd;
        logic signed [VALUE_W-1:0] value;
        logic        [PRIO_W-1:0]  prio;
    } cell_op_t;

endpackage

// ===== hdl/stable_priority_queue_top.sv =====
`timescale 1ns / 1ps
// Top level of the stable sorted priority queue: a chain of spq_cell instances
// plus the command decode, occupancy counter and registered result word.
// Depends on spq_pkg and spq_cell.

// The queue takes one command word per clock cycle: busy never rises, so a
// word may be issued with start in every cycle. The result word for a command
// appears on the cycle right after it is accepted, marked by done for exactly
// one cycle; the receiver cannot stall it and must take it then. The cell
// chain makes this possible: every cell compares its own priority with
// the incoming one in parallel and updates in the same cycle. Cell 0 always
// holds the most urgent entry (lowest priority number), and entries of equal
// priority leave in the order they arrived. A dequeue on an empty queue and an
// enqueue into a full queue change nothing and report their own status codes.
// Occupancy reports the low five bits of the number of entries held after the
// command.
module stable_priority_queue_top
#(
    parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               command,
    input  logic signed [spq_pkg::VALUE_W-1:0] in_value,
    input  logic        [spq_pkg::PRIO_W-1:0]  in_priority,
    output logic                               done,
    output logic        [spq_pkg::STATUS_W-1:0] status,
    output logic signed [spq_pkg::VALUE_W-1:0] out_value,
    output logic        [spq_pkg::PRIO_W-1:0]  out_priority,
    output logic        [spq_pkg::OCC_W-1:0]   occupancy
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    spq_pkg::cell_data_t cells [DEPTH];
    spq_pkg::cell_data_t head;
    spq_pkg::cell_data_t tail;
    spq_pkg::cell_op_t   op;
    logic [DEPTH-1:0]    valid_vec;

    logic        accept;
    logic        is_deq;
    logic        full;
    logic        empty;
    logic        enq_ok;
    logic        deq_ok;

    logic [CNT_W-1:0]                    count_reg;
    logic [CNT_W-1:0]                    count_next;
    logic                                done_reg;
    spq_pkg::status_t                    status_reg;
    spq_pkg::status_t                    status_next;
    logic signed [spq_pkg::VALUE_W-1:0]  out_value_reg;
    logic signed [spq_pkg::VALUE_W-1:0]  out_value_next;
    logic        [spq_pkg::PRIO_W-1:0]   out_priority_reg;
    logic        [spq_pkg::PRIO_W-1:0]   out_priority_next;

    // The chain never stalls a command.
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign is_deq = (spq_pkg::cmd_t'(command) == spq_pkg::CMD_DEQ);

    // Valid cells always form a run from cell 0, so the ends tell full and empty.
    assign full   = cells[DEPTH-1].valid;
    assign empty  = !cells[0].valid;
    assign enq_ok = accept && !is_deq && !full;
    assign deq_ok = accept && is_deq && !empty;

    // The virtual cell ahead of cell 0 is valid with the most urgent priority,
    // so cell 0 never sees a shift from the left and may load a new entry.
    assign head.valid = 1'b1;
    assign head.value = '0;
    assign head.prio  = '0;

    // Past the last cell there is nothing; a dequeue shifts in an empty cell.
    assign tail.valid = 1'b0;
    assign tail.value = '0;
    assign tail.prio  = '0;

    // Dropped or failed commands do not reach the cells at all.
    assign op.en    = enq_ok || deq_ok;
    assign op.cmd   = spq_pkg::cmd_t'(command);
    assign op.value = in_value;
    assign op.prio  = in_priority;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        spq_pkg::cell_data_t left_data;
        spq_pkg::cell_data_t right_data;

        if (i == 0)
        begin : g_first
            assign left_data = head;
        end
        else
        begin : g_mid_l
            assign left_data = cells[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_data = tail;
        end
        else
        begin : g_mid_r
            assign right_data = cells[i+1];
        end

        spq_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .op    (op),
            .left  (left_data),
            .right (right_data),
            .data  (cells[i])
        );

        assign valid_vec[i] = cells[i].valid;
    end

    // Result word and occupancy count.
    always_comb
    begin
        count_next        = count_reg;
        status_next       = spq_pkg::ST_DONE;
        out_value_next    = '0;
        out_priority_next = '0;
        if (accept)
        begin
            if (is_deq)
            begin
                if (empty)
                begin
                    status_next = spq_pkg::ST_EMPTY;
                end
                else
                begin
                    out_value_next    = cells[0].value;
                    out_priority_next = cells[0].prio;
                    count_next        = count_reg - CNT_W'(1);
                end
            end
            else
            begin
                if (full)
                begin
                    status_next = spq_pkg::ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg  <= accept;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg       <= status_next;
        out_value_reg    <= out_value_next;
        out_priority_reg <= out_priority_next;
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign out_value    = out_value_reg;
    assign out_priority = out_priority_reg;
    assign occupancy    = spq_pkg::OCC_W'(count_reg);

`ifndef ASSERT_OFF
    // The counter must always agree with the number of valid cells.
    a_count_matches_cells: assert property (
        @(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(count_reg)
    ) else $error("occupancy counter disagrees with valid cells");

    // Every accepted command yields its result word on the next cycle.
    a_result_follows: assert property (
        @(posedge clk) disable iff (!rst_n)
        accept |=> done
    ) else $error("accepted command produced no result word");

    // An empty-queue report only happens when nothing is held.
    a_empty_report: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && status == spq_pkg::ST_EMPTY) |-> (count_reg == '0)
    ) else $error("empty status reported with entries held");

    // A dropped enqueue only happens when every cell is occupied.
    a_full_report: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && status == spq_pkg::ST_FULL) |-> (int'(count_reg) == DEPTH)
    ) else $error("full status reported with a free cell");
`endif

endmodule

// ===== hdl/spq_cell.sv =====
`timescale 1ns / 1ps
// One cell of the sorted queue chain: holds one entry and decides each cycle
// whether to keep it, take its left or right neighbor's entry, or load the new one.
// Depends on spq_pkg.
module spq_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  spq_pkg::cell_op_t   op,
    input  spq_pkg::cell_data_t left,
    input  spq_pkg::cell_data_t right,
    output spq_pkg::cell_data_t data
);

    logic                              valid_reg;
    logic                              valid_next;
    logic signed [spq_pkg::VALUE_W-1:0] value_reg;
    logic signed [spq_pkg::VALUE_W-1:0] value_next;
    logic        [spq_pkg::PRIO_W-1:0]  prio_reg;
    logic        [spq_pkg::PRIO_W-1:0]  prio_next;
    logic                              left_gt;
    logic                              mine_gt;

    always_comb
    begin
        left_gt    = left.valid && (left.prio > op.prio);
        mine_gt    = valid_reg && (prio_reg > op.prio);
        valid_next = valid_reg;
        value_next = value_reg;
        prio_next  = prio_reg;
        if (op.en)
        begin
            if (op.cmd == spq_pkg::CMD_DEQ)
            begin
                valid_next = right.valid;
                value_next = right.value;
                prio_next  = right.prio;
            end
            else if (left_gt)
            begin
                // The insertion point lies to the left, so everything shifts right.
                valid_next = left.valid;
                value_next = left.value;
                prio_next  = left.prio;
            end
            else if (left.valid && (!valid_reg || mine_gt))
            begin
                valid_next = 1'b1;
                value_next = op.value;
                prio_next  = op.prio;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

    assign data.valid = valid_reg;
    assign data.value = value_reg;
    assign data.prio  = prio_reg;

endmodule
